@@ hdl/pfdc_pkg.sv @@
`timescale 1ns / 1ps
package pfdc_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int ACC_WIDTH  = 48;
    localparam int WIDE_BITS  = 64;
    localparam int CFG_WIDTH  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int DT_WIDTH   = 16;
    localparam int DIV_STEPS  = 80;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FF_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_DECAY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FF_ENABLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 3'd6;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] setpoint;
        logic signed [DATA_WIDTH-1:0] measurement;
        logic [DT_WIDTH-1:0]          time_step;
        logic                         restart;
    } pfdc_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] drive;
        logic                         saturated;
    } pfdc_out_t;

    typedef struct packed {
        logic signed [CFG_WIDTH-1:0] prop_gain;
        logic signed [CFG_WIDTH-1:0] integ_gain;
        logic signed [CFG_WIDTH-1:0] deriv_gain;
        logic signed [CFG_WIDTH-1:0] ff_gain;
        logic [CFG_WIDTH-1:0]        integ_decay;
        logic                        ff_enable;
        logic                        loop_enable;
    } cfg_t;

    // micro-operations, in the order the sequencer walks them
    typedef enum logic [3:0] {
        UOP_ERR, UOP_DIFF, UOP_DERIV, UOP_DECAY, UOP_INFLOW, UOP_ACC, UOP_INTEG,
        UOP_KI, UOP_BRK1, UOP_KD, UOP_BRK2, UOP_KP, UOP_FF, UOP_FFADD, UOP_FINISH
    } uop_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic capture;
        uop_t uop;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic ff_enable;
    } sts_t;

    typedef struct packed {
        logic [WIDE_BITS-1:0] val;
        logic                 clip;
    } sat_t;

    function automatic logic uop_is_mul(uop_t u);
        return (u == UOP_DECAY) || (u == UOP_INFLOW) || (u == UOP_KI) ||
               (u == UOP_KD) || (u == UOP_KP) || (u == UOP_FF);
    endfunction

    function automatic logic uop_is_div(uop_t u);
        return (u == UOP_DERIV) || (u == UOP_INTEG);
    endfunction

    function automatic logic [WIDE_BITS-1:0] mag64(logic [WIDE_BITS-1:0] x);
        return x[WIDE_BITS-1] ? (~x + 64'd1) : x;
    endfunction

    function automatic logic [WIDE_BITS-1:0] sx24(logic [CFG_WIDTH-1:0] g);
        return {{(WIDE_BITS-CFG_WIDTH){g[CFG_WIDTH-1]}}, g};
    endfunction

    // clamp a sign and magnitude into a w-bit signed range, sign-extended to 64
    function automatic sat_t pack_sat(logic neg, logic [WIDE_BITS-1:0] m, int unsigned w);
        logic [WIDE_BITS:0] lim;
        logic [WIDE_BITS:0] lim_m1;
        sat_t r;
        lim    = 65'd1 << (w - 1);
        lim_m1 = lim - 65'd1;
        r.clip = 1'b0;
        if (neg) begin
            if ({1'b0, m} > lim) begin
                r.val  = ~lim[WIDE_BITS-1:0] + 64'd1;
                r.clip = 1'b1;
            end else begin
                r.val = ~m + 64'd1;
            end
        end else begin
            if ({1'b0, m} > lim_m1) begin
                r.val  = lim_m1[WIDE_BITS-1:0];
                r.clip = 1'b1;
            end else begin
                r.val = m;
            end
        end
        return r;
    endfunction

    function automatic sat_t addsm(logic na, logic [WIDE_BITS-1:0] ma,
                                   logic nb, logic [WIDE_BITS-1:0] mb, int unsigned w);
        logic [WIDE_BITS:0] s;
        sat_t r;
        s = {1'b0, ma} + {1'b0, mb};
        if (na == nb) begin
            r = pack_sat(na, s[WIDE_BITS] ? {WIDE_BITS{1'b1}} : s[WIDE_BITS-1:0], w);
        end else if (ma >= mb) begin
            r = pack_sat(na, ma - mb, w);
        end else begin
            r = pack_sat(nb, mb - ma, w);
        end
        return r;
    endfunction

    function automatic sat_t add_sat(logic [WIDE_BITS-1:0] a, logic [WIDE_BITS-1:0] b,
                                     int unsigned w);
        return addsm(a[WIDE_BITS-1], mag64(a), b[WIDE_BITS-1], mag64(b), w);
    endfunction

    function automatic sat_t sub_sat(logic [WIDE_BITS-1:0] a, logic [WIDE_BITS-1:0] b,
                                     int unsigned w);
        return addsm(a[WIDE_BITS-1], mag64(a), !b[WIDE_BITS-1], mag64(b), w);
    endfunction

endpackage

@@ hdl/pfdc_mul.sv @@
`timescale 1ns / 1ps
module pfdc_mul (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] prod
);
    import pfdc_pkg::*;

    logic [63:0]  a_reg, b_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg, done_reg, pp_vld_reg;
    logic [1:0]   pp_idx_reg;
    logic [63:0]  pp_reg;
    logic [127:0] prod_reg;
    logic [31:0]  a_half, b_half;
    logic [63:0]  pp_c;
    logic [127:0] addend;

    // pick one pair of 32-bit halves per cycle
    always_comb begin
        a_half = cnt_reg[0] ? a_reg[63:32] : a_reg[31:0];
        b_half = cnt_reg[1] ? b_reg[63:32] : b_reg[31:0];
        pp_c   = a_half * b_half;
        unique case (pp_idx_reg)
            2'd0:    addend = {64'd0, pp_reg};
            2'd3:    addend = {pp_reg, 64'd0};
            default: addend = {32'd0, pp_reg, 32'd0};
        endcase
    end

    // registered partial product, then accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            pp_vld_reg <= 1'b0;
            cnt_reg    <= 3'd0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 3'd4);
            if (start) begin
                a_reg      <= a;
                b_reg      <= b;
                cnt_reg    <= 3'd0;
                busy_reg   <= 1'b1;
                pp_vld_reg <= 1'b0;
                prod_reg   <= 128'd0;
            end else if (busy_reg) begin
                if (cnt_reg != 3'd4) begin
                    pp_reg     <= pp_c;
                    pp_idx_reg <= cnt_reg[1:0];
                    pp_vld_reg <= 1'b1;
                end else begin
                    pp_vld_reg <= 1'b0;
                    busy_reg   <= 1'b0;
                end
                if (pp_vld_reg) begin
                    prod_reg <= prod_reg + addend;
                end
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

@@ hdl/pfdc_div.sv @@
`timescale 1ns / 1ps
module pfdc_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dvd,
    input  logic [31:0] dvs,
    output logic        done,
    output logic [63:0] quo
);
    import pfdc_pkg::*;

    logic [DIV_STEPS-1:0] work_reg;
    logic [31:0]          rem_reg, dvs_reg;
    logic [6:0]           cnt_reg;
    logic                 busy_reg, done_reg;
    logic [32:0]          rem_sh, rem_sub;
    logic                 ge;

    // one restoring step per cycle on the dividend scaled by 2^16
    always_comb begin
        rem_sh  = {rem_reg, work_reg[DIV_STEPS-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        ge      = rem_sh >= {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                work_reg <= {dvd, 16'd0};
                dvs_reg  <= dvs;
                rem_reg  <= 32'd0;
                cnt_reg  <= 7'd0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= ge ? rem_sub[31:0] : rem_sh[31:0];
                work_reg <= {work_reg[DIV_STEPS-2:0], ge};
                cnt_reg  <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient beyond 64 bits clamps to all ones
    assign quo  = (|work_reg[DIV_STEPS-1:64]) ? {64{1'b1}} : work_reg[63:0];
    assign done = done_reg;

endmodule

@@ hdl/pfdc_datapath.sv @@
`timescale 1ns / 1ps
module pfdc_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  pfdc_pkg::pfdc_in_t  in_item,
    input  pfdc_pkg::cfg_t      cfg,
    input  pfdc_pkg::cmd_t      cmd,
    output pfdc_pkg::sts_t      sts,
    output pfdc_pkg::pfdc_out_t res
);
    import pfdc_pkg::*;

    logic [63:0]  sp_reg, ms_reg, err_reg, prev_reg, acc_reg;
    logic [63:0]  tmp_reg, term_reg, deriv_reg, brk_reg;
    logic [15:0]  dt_reg;
    logic         acc_clip_reg, drv_clip_reg;
    logic         mul_neg_reg, div_neg_reg;
    pfdc_out_t    res_reg;

    logic [63:0]  mul_a, mul_b, mul_r, div_m;
    logic [31:0]  div_d;
    logic [24:0]  one_minus_decay;
    logic         mul_ovf, mul_start, div_start, mul_done, div_done;
    logic [127:0] prod;
    logic [63:0]  quo;
    sat_t         mul_res_acc, mul_res_wide, div_res;
    sat_t         err_s, diff_s, acc_s, brk1_s, brk_s, drive_s;

    assign one_minus_decay = 25'h1000000 - {1'b0, cfg.integ_decay};

    // operand selection for the shared units
    always_comb begin
        mul_a = 64'd0;
        mul_b = 64'd0;
        div_m = mag64(tmp_reg);
        div_d = {16'd0, dt_reg};
        unique case (cmd.uop)
            UOP_DECAY: begin
                mul_a = acc_reg;
                mul_b = {40'd0, cfg.integ_decay};
            end
            UOP_INFLOW: begin
                mul_a = err_reg;
                mul_b = {48'd0, dt_reg};
            end
            UOP_KI: begin
                mul_a = sx24(cfg.integ_gain);
                mul_b = tmp_reg;
            end
            UOP_KD: begin
                mul_a = sx24(cfg.deriv_gain);
                mul_b = deriv_reg;
            end
            UOP_KP: begin
                mul_a = sx24(cfg.prop_gain);
                mul_b = brk_reg;
            end
            UOP_FF: begin
                mul_a = sx24(cfg.ff_gain);
                mul_b = sp_reg;
            end
            UOP_INTEG: begin
                div_m = mag64(acc_reg);
                div_d = {7'd0, one_minus_decay};
            end
            default: begin
            end
        endcase
    end

    assign mul_start = cmd.issue && uop_is_mul(cmd.uop);
    assign div_start = cmd.issue && uop_is_div(cmd.uop);

    pfdc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mag64(mul_a)),
        .b       (mag64(mul_b)),
        .done    (mul_done),
        .prod    (prod)
    );

    pfdc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dvd     (div_m),
        .dvs     (div_d),
        .done    (div_done),
        .quo     (quo)
    );

    // scale the product back and clamp
    always_comb begin
        unique case (cmd.uop)
            UOP_DECAY: begin
                mul_r   = prod[24 +: 64];
                mul_ovf = |prod[127:88];
            end
            UOP_INFLOW: begin
                mul_r   = prod[8 +: 64];
                mul_ovf = |prod[127:72];
            end
            default: begin
                mul_r   = prod[16 +: 64];
                mul_ovf = |prod[127:80];
            end
        endcase
        mul_res_acc  = pack_sat(mul_neg_reg, mul_ovf ? {64{1'b1}} : mul_r, ACC_WIDTH);
        mul_res_wide = pack_sat(mul_neg_reg, mul_ovf ? {64{1'b1}} : mul_r, WIDE_BITS);
        div_res      = pack_sat(div_neg_reg, quo, WIDE_BITS);
    end

    // saturating adders for the steps that use neither shared unit
    always_comb begin
        err_s   = sub_sat(sp_reg, ms_reg, DATA_WIDTH);
        diff_s  = sub_sat(err_reg, prev_reg, WIDE_BITS);
        acc_s   = add_sat(tmp_reg, term_reg, ACC_WIDTH);
        brk1_s  = add_sat(err_reg, term_reg, WIDE_BITS);
        brk_s   = add_sat(brk_reg, term_reg, WIDE_BITS);
        drive_s = add_sat(brk_reg, 64'd0, DATA_WIDTH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= 64'd0;
            prev_reg     <= 64'd0;
            acc_clip_reg <= 1'b0;
            drv_clip_reg <= 1'b0;
        end else if (cmd.load) begin
            // take the item, apply restart
            sp_reg <= {{(WIDE_BITS-DATA_WIDTH){in_item.setpoint[DATA_WIDTH-1]}},
                       in_item.setpoint};
            ms_reg <= {{(WIDE_BITS-DATA_WIDTH){in_item.measurement[DATA_WIDTH-1]}},
                       in_item.measurement};
            dt_reg <= (in_item.time_step == 16'd0) ? 16'd1 : in_item.time_step;
            if (in_item.restart) begin
                acc_reg  <= 64'd0;
                prev_reg <= 64'd0;
            end
            acc_clip_reg <= 1'b0;
            drv_clip_reg <= 1'b0;
        end else if (cmd.issue) begin
            unique case (cmd.uop)
                UOP_ERR: begin
                    err_reg      <= err_s.val;
                    drv_clip_reg <= drv_clip_reg | err_s.clip;
                end
                UOP_DIFF: begin
                    tmp_reg      <= diff_s.val;
                    drv_clip_reg <= drv_clip_reg | diff_s.clip;
                end
                UOP_ACC: begin
                    acc_reg      <= acc_s.val;
                    acc_clip_reg <= acc_clip_reg | acc_s.clip;
                end
                UOP_BRK1: begin
                    brk_reg      <= brk1_s.val;
                    drv_clip_reg <= drv_clip_reg | brk1_s.clip;
                end
                UOP_BRK2, UOP_FFADD: begin
                    brk_reg      <= brk_s.val;
                    drv_clip_reg <= drv_clip_reg | brk_s.clip;
                end
                UOP_FINISH: begin
                    prev_reg <= err_reg;
                    if (cfg.loop_enable) begin
                        res_reg.drive     <= drive_s.val[DATA_WIDTH-1:0];
                        res_reg.saturated <= acc_clip_reg | drv_clip_reg | drive_s.clip;
                    end else begin
                        res_reg.drive     <= sp_reg[DATA_WIDTH-1:0];
                        res_reg.saturated <= acc_clip_reg;
                    end
                end
                default: begin
                    // latch the result sign for the shared units
                    mul_neg_reg <= mul_a[63] ^ mul_b[63];
                    div_neg_reg <= (cmd.uop == UOP_INTEG) ? acc_reg[63] : tmp_reg[63];
                end
            endcase
        end else if (mul_done) begin
            unique case (cmd.uop)
                UOP_DECAY: begin
                    tmp_reg      <= mul_res_acc.val;
                    acc_clip_reg <= acc_clip_reg | mul_res_acc.clip;
                end
                UOP_INFLOW: begin
                    term_reg     <= mul_res_acc.val;
                    acc_clip_reg <= acc_clip_reg | mul_res_acc.clip;
                end
                UOP_KP: begin
                    brk_reg      <= mul_res_wide.val;
                    drv_clip_reg <= drv_clip_reg | mul_res_wide.clip;
                end
                default: begin
                    term_reg     <= mul_res_wide.val;
                    drv_clip_reg <= drv_clip_reg | mul_res_wide.clip;
                end
            endcase
        end else if (div_done) begin
            if (cmd.uop == UOP_INTEG) begin
                tmp_reg <= div_res.val;
            end else begin
                deriv_reg <= div_res.val;
            end
            drv_clip_reg <= drv_clip_reg | div_res.clip;
        end
    end

    assign sts.mul_done  = mul_done;
    assign sts.div_done  = div_done;
    assign sts.ff_enable = cfg.ff_enable;
    assign res           = res_reg;

endmodule

@@ hdl/pfdc_ctrl.sv @@
`timescale 1ns / 1ps
module pfdc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           out_free,
    input  pfdc_pkg::sts_t sts,
    output pfdc_pkg::cmd_t cmd
);
    import pfdc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_HOLD  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    uop_t   uop_reg, uop_next;
    uop_t   uop_succ;

    // step order; feedforward pair only when enabled
    always_comb begin
        unique case (uop_reg)
            UOP_ERR:    uop_succ = UOP_DIFF;
            UOP_DIFF:   uop_succ = UOP_DERIV;
            UOP_DERIV:  uop_succ = UOP_DECAY;
            UOP_DECAY:  uop_succ = UOP_INFLOW;
            UOP_INFLOW: uop_succ = UOP_ACC;
            UOP_ACC:    uop_succ = UOP_INTEG;
            UOP_INTEG:  uop_succ = UOP_KI;
            UOP_KI:     uop_succ = UOP_BRK1;
            UOP_BRK1:   uop_succ = UOP_KD;
            UOP_KD:     uop_succ = UOP_BRK2;
            UOP_BRK2:   uop_succ = UOP_KP;
            UOP_KP:     uop_succ = sts.ff_enable ? UOP_FF : UOP_FINISH;
            UOP_FF:     uop_succ = UOP_FFADD;
            default:    uop_succ = UOP_FINISH;
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        uop_next    = uop_reg;
        s_ready     = (state_reg == ST_IDLE);
        cmd.load    = (state_reg == ST_IDLE) && s_valid;
        cmd.issue   = 1'b0;
        cmd.capture = 1'b0;
        cmd.uop     = uop_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_ISSUE;
                    uop_next   = UOP_ERR;
                end
            end
            ST_ISSUE: begin
                cmd.issue = 1'b1;
                if (uop_is_mul(uop_reg) || uop_is_div(uop_reg)) begin
                    state_next = ST_WAIT;
                end else if (uop_reg == UOP_FINISH) begin
                    state_next = ST_HOLD;
                end else begin
                    uop_next = uop_succ;
                end
            end
            ST_WAIT: begin
                if ((uop_is_mul(uop_reg) && sts.mul_done) ||
                    (uop_is_div(uop_reg) && sts.div_done)) begin
                    uop_next   = uop_succ;
                    state_next = ST_ISSUE;
                end
            end
            ST_HOLD: begin
                // hand the item over once the output register is free
                if (out_free) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            uop_reg   <= UOP_ERR;
        end else begin
            state_reg <= state_next;
            uop_reg   <= uop_next;
        end
    end

endmodule

@@ hdl/pid_feedforward_decay_controller.sv @@
`timescale 1ns / 1ps
// PID controller with setpoint feedforward and a leaky integral, Q16.16 data.
// One item is worked at a time. With the output register free, the result
// appears there and the next item can be accepted in the same cycle. Most of
// the time goes to the two divisions (derivative and integral): each is 80
// steps of the bit-serial divider. The five or six products share one 32x32
// multiplier; each takes four partial products. The remaining steps are
// saturating adds. A finished result waits in the output register until
// taken. The next item is accepted while it waits, but that item's own result
// cannot be handed over until the register is free. Configuration writes take
// effect at once and belong between items.
module pid_feedforward_decay_controller (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  pfdc_pkg::pfdc_in_t                     s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output pfdc_pkg::pfdc_out_t                    m_data,
    input  logic                                   cfg_wen,
    input  logic [pfdc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pfdc_pkg::CFG_WIDTH-1:0]         cfg_wdata
);
    import pfdc_pkg::*;

    cfg_t      cfg_reg;
    cmd_t      cmd;
    sts_t      sts;
    pfdc_out_t res;
    pfdc_out_t m_data_reg;
    logic      m_valid_reg;
    logic      out_free;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain   <= '0;
            cfg_reg.integ_gain  <= '0;
            cfg_reg.deriv_gain  <= '0;
            cfg_reg.ff_gain     <= '0;
            cfg_reg.integ_decay <= '0;
            cfg_reg.ff_enable   <= 1'b0;
            cfg_reg.loop_enable <= 1'b1;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                CFG_PROP_GAIN:   cfg_reg.prop_gain   <= cfg_wdata;
                CFG_INTEG_GAIN:  cfg_reg.integ_gain  <= cfg_wdata;
                CFG_DERIV_GAIN:  cfg_reg.deriv_gain  <= cfg_wdata;
                CFG_FF_GAIN:     cfg_reg.ff_gain     <= cfg_wdata;
                CFG_INTEG_DECAY: cfg_reg.integ_decay <= cfg_wdata;
                CFG_FF_ENABLE:   cfg_reg.ff_enable   <= cfg_wdata[0];
                CFG_LOOP_ENABLE: cfg_reg.loop_enable <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    pfdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    pfdc_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_item (s_data),
        .cfg     (cfg_reg),
        .cmd     (cmd),
        .sts     (sts),
        .res     (res)
    );

    // output register: hold the item until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.capture) begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= res;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item accepted while another is in work");

    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sts.mul_done && sts.div_done))
        else $error("multiplier and divider finished together");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> (!m_valid || m_ready))
        else $error("result written over a waiting item");

endmodule

@@ sim/pid_feedforward_decay_controller_test.sv @@
`timescale 1ns / 1ps
module pid_feedforward_decay_controller_test;
    import pfdc_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    pfdc_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    pfdc_out_t m_data;
    logic                 cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PROP_GAIN;
    logic [CFG_WIDTH-1:0] cfg_wdata = '0;

    pid_feedforward_decay_controller dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // controller copy: gains, decay, enables, and the loop state
    logic [CFG_WIDTH-1:0] kp, ki, kd, kff, decay;
    logic                 ff_on, loop_on;
    logic signed [63:0]   acc_state, last_err;

    pfdc_out_t drive_expected[$];
    int        mismatches = 0;
    int        items_sent = 0;
    int        results_seen = 0;
    int        clipped_seen = 0;
    bit        idling_on = 1'b1;
    int        cycles = 0;
    int        ready_hold = 0;

    function automatic logic [63:0] magnitude(logic signed [63:0] x);
        return x < 0 ? -x : x;
    endfunction

    // clamp sign and magnitude into a w-bit signed range
    function automatic logic signed [63:0] clamp_w(bit neg, logic [63:0] m, int w,
                                                  inout bit clip);
        logic [64:0] lim;
        lim = 65'd1 << (w - 1);
        if (neg) begin
            if ({1'b0, m} > lim) begin
                m = lim[63:0];
                clip = 1'b1;
            end
            return -m;
        end
        if ({1'b0, m} > lim - 65'd1) begin
            m = lim[63:0] - 64'd1;
            clip = 1'b1;
        end
        return m;
    endfunction

    function automatic logic signed [63:0] sm_add(bit na, logic [63:0] ma, bit nb,
                                                 logic [63:0] mb, int w, inout bit clip);
        logic [64:0] s;
        s = {1'b0, ma} + {1'b0, mb};
        if (na == nb) return clamp_w(na, s[64] ? '1 : s[63:0], w, clip);
        if (ma >= mb) return clamp_w(na, ma - mb, w, clip);
        return clamp_w(nb, mb - ma, w, clip);
    endfunction

    function automatic logic signed [63:0] sat_plus(logic signed [63:0] a,
                                                   logic signed [63:0] b, int w, inout bit clip);
        return sm_add(a < 0, magnitude(a), b < 0, magnitude(b), w, clip);
    endfunction

    function automatic logic signed [63:0] sat_minus(logic signed [63:0] a,
                                                    logic signed [63:0] b, int w, inout bit clip);
        return sm_add(a < 0, magnitude(a), !(b < 0), magnitude(b), w, clip);
    endfunction

    // product shifted toward zero, saturated
    function automatic logic signed [63:0] mul_shift(logic signed [63:0] a,
                                                    logic signed [63:0] b, int sh, int w,
                                                    inout bit clip);
        logic [127:0] p;
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        p = p >> sh;
        return clamp_w((a < 0) != (b < 0), (p[127:64] != 0) ? '1 : p[63:0], w, clip);
    endfunction

    // scaled quotient toward zero, saturated
    function automatic logic signed [63:0] div_shift(logic signed [63:0] a, logic [63:0] d,
                                                    int sh, int w, inout bit clip);
        logic [127:0] q;
        q = ({64'd0, magnitude(a)} << sh) / {64'd0, d};
        return clamp_w(a < 0, (q[127:64] != 0) ? '1 : q[63:0], w, clip);
    endfunction

    function automatic logic signed [63:0] gain64(logic [CFG_WIDTH-1:0] g);
        return {{(64 - CFG_WIDTH){g[CFG_WIDTH-1]}}, g};
    endfunction

    // advance the controller copy by one item and return its result
    function automatic pfdc_out_t pid_predict(pfdc_in_t it);
        logic signed [63:0] sp, ms, err, diff, deriv, decayed, inflow, integ, brk, pid, drv;
        logic [63:0] dt;
        bit acc_clip, drv_clip;
        pfdc_out_t o;
        acc_clip = 1'b0;
        drv_clip = 1'b0;
        sp = {{32{it.setpoint[31]}}, it.setpoint};
        ms = {{32{it.measurement[31]}}, it.measurement};
        dt = (it.time_step == 0) ? 64'd1 : {48'd0, it.time_step};
        if (it.restart) begin
            acc_state = 0;
            last_err = 0;
        end
        err = sat_minus(sp, ms, DATA_WIDTH, drv_clip);
        diff = sat_minus(err, last_err, 64, drv_clip);
        deriv = div_shift(diff, dt, 16, 64, drv_clip);
        decayed = mul_shift(acc_state, {40'd0, decay}, 24, ACC_WIDTH, acc_clip);
        inflow = mul_shift(err, dt, 8, ACC_WIDTH, acc_clip);
        acc_state = sat_plus(decayed, inflow, ACC_WIDTH, acc_clip);
        integ = div_shift(acc_state, (64'd1 << 24) - {40'd0, decay}, 16, 64, drv_clip);
        brk = sat_plus(err, mul_shift(gain64(ki), integ, 16, 64, drv_clip), 64, drv_clip);
        brk = sat_plus(brk, mul_shift(gain64(kd), deriv, 16, 64, drv_clip), 64, drv_clip);
        pid = mul_shift(gain64(kp), brk, 16, 64, drv_clip);
        if (ff_on)
            pid = sat_plus(pid, mul_shift(gain64(kff), sp, 16, 64, drv_clip), 64, drv_clip);
        drv = sat_plus(pid, 0, DATA_WIDTH, drv_clip);
        last_err = err;
        if (loop_on) begin
            o.drive = drv[31:0];
            o.saturated = acc_clip | drv_clip;
        end else begin
            o.drive = sp[31:0];
            o.saturated = acc_clip;
        end
        return o;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s at result %0d: got %h, want %h",
                 what, results_seen, got, want);
        mismatches++;
    endtask

    // check each accepted result against the oldest expectation
    always @(posedge aclk) begin
        pfdc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (drive_expected.size() == 0) begin
                report("unexpected item", m_data.drive, 32'd0);
            end else begin
                want = drive_expected.pop_front();
                if (m_data.drive !== want.drive) report("drive", m_data.drive, want.drive);
                if (m_data.saturated !== want.saturated)
                    report("saturated", {31'd0, m_data.saturated}, {31'd0, want.saturated});
                if (want.saturated) clipped_seen++;
            end
            results_seen++;
        end
    end

    // result-side stalls in random bursts
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            ready_hold <= $urandom_range(0, 11);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // end the run if it hangs
    always @(posedge aclk) begin
        cycles++;
        if (cycles > 3000000) begin
            $display("pid_feedforward_decay_controller_test: errors");
            $finish;
        end
    end

    // write all registers back to back, then drop the enable
    task automatic write_regs(logic [23:0] p, logic [23:0] i, logic [23:0] d,
                              logic [23:0] f, logic [23:0] dec, bit ffe, bit le);
        logic [CFG_WIDTH-1:0] vals[7];
        logic [CFG_IDX_W-1:0] idx[7];
        vals = '{p, i, d, f, dec, {23'd0, ffe}, {23'd0, le}};
        idx = '{CFG_PROP_GAIN, CFG_INTEG_GAIN, CFG_DERIV_GAIN, CFG_FF_GAIN,
                CFG_INTEG_DECAY, CFG_FF_ENABLE, CFG_LOOP_ENABLE};
        for (int n = 0; n < 7; n++) begin
            cfg_wen <= 1'b1;
            cfg_index <= idx[n];
            cfg_wdata <= vals[n];
            @(posedge aclk);
        end
        cfg_wen <= 1'b0;
        @(posedge aclk);
        kp = p; ki = i; kd = d; kff = f; decay = dec; ff_on = ffe; loop_on = le;
    endtask

    // offer one item, hold it until accepted, then maybe pause
    task automatic send_item(pfdc_in_t it);
        int gap;
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        drive_expected.push_back(pid_predict(it));
        items_sent++;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // drop valid and hold until every expected item has come back
    task automatic drain;
        s_valid <= 1'b0;
        while (drive_expected.size() != 0) @(posedge aclk);
        repeat (260) @(posedge aclk);
    endtask

    function automatic pfdc_in_t make_item(logic [31:0] sp, logic [31:0] ms,
                                           logic [15:0] dt, bit rs);
        pfdc_in_t it;
        it.setpoint = sp;
        it.measurement = ms;
        it.time_step = dt;
        it.restart = rs;
        return it;
    endfunction

    // mostly tracking steps with small error, some wild values and restarts
    function automatic pfdc_in_t random_item();
        logic [31:0] sp, ms;
        logic [15:0] dt;
        sp = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h000F_FFFF)
                                                    - 32'h0008_0000;
        ms = $urandom_range(0, 3) == 0 ? $urandom : sp + $urandom_range(0, 32'h0003_FFFF)
                                                    - 32'h0002_0000;
        case ($urandom_range(0, 3))
            0: dt = 16'($urandom);
            1: dt = 16'($urandom_range(0, 3));
            default: dt = 16'($urandom_range(256, 8192));
        endcase
        return make_item(sp, ms, dt, $urandom_range(0, 19) == 0);
    endfunction

    function automatic logic [23:0] random_gain();
        case ($urandom_range(0, 5))
            0: return 24'h7F_FFFF;
            1: return 24'h80_0000;
            2: return 24'($urandom);
            default: return 24'($urandom_range(0, 24'h03_FFFF) - 24'h01_0000);
        endcase
    endfunction

    task automatic test_directed;
        write_regs(24'h01_0000, 24'h00_8000, 24'h00_0100, 24'h00_8000, 24'h80_0000, 1'b1, 1'b1);
        send_item(make_item(32'h0001_0000, 32'h0000_0000, 16'h1000, 1'b1));
        send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b0));
        send_item(make_item(32'h8000_0000, 32'h7FFF_FFFF, 16'h0001, 1'b0));
        send_item(make_item(32'h8000_0000, 32'h8000_0000, 16'h0000, 1'b0));
        send_item(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000, 1'b1));
        send_item(make_item(32'hFFFF_FFFF, 32'h0000_0001, 16'h0001, 1'b0));
        send_item(make_item(32'h0000_0000, 32'hFFFF_0000, 16'h8000, 1'b0));
        drain();
        // loop disabled: setpoint passes through, state still moves
        write_regs(24'h7F_FFFF, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF, 24'hFF_FFFF, 1'b1, 1'b0);
        send_item(make_item(32'h1234_5678, 32'h8000_0000, 16'hFFFF, 1'b0));
        send_item(make_item(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b0));
        send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b0));
        send_item(make_item(32'h0000_0000, 32'h0000_0000, 16'h0001, 1'b1));
        drain();
        write_regs(24'h80_0000, 24'h80_0000, 24'h7F_FFFF, 24'h80_0000, 24'hFF_FFFF, 1'b1, 1'b1);
        for (int n = 0; n < 6; n++)
            send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, n == 3));
        drain();
    endtask

    task automatic test_extremes;
        logic [23:0] g;
        for (int s = 0; s < 4; s++) begin
            g = s[0] ? 24'h7F_FFFF : 24'h80_0000;
            write_regs(g, g, ~g, g, s[1] ? 24'hFF_FFFF : 24'h00_0000, s[0], 1'b1);
            for (int n = 0; n < 30; n++) send_item(random_item());
            drain();
        end
    endtask

    task automatic test_random_settings;
        for (int s = 0; s < 8; s++) begin
            write_regs(random_gain(), random_gain(), random_gain(), random_gain(),
                       $urandom_range(0, 2) == 0 ? 24'($urandom)
                                                 : 24'h F0_0000 + 24'($urandom_range(0, 24'h0F_FFFF)),
                       $urandom_range(0, 1) != 0, $urandom_range(0, 5) != 0);
            for (int n = 0; n < 75; n++) send_item(random_item());
            drain();
        end
    endtask

    task automatic test_full_rate;
        idling_on = 1'b0;
        write_regs(24'h01_8000, 24'h00_4000, 24'h00_0800, 24'h00_C000, 24'hE0_0000, 1'b1, 1'b1);
        for (int n = 0; n < 110; n++) send_item(random_item());
        drain();
    endtask

    initial begin
        kp = '0; ki = '0; kd = '0; kff = '0; decay = '0;
        ff_on = 1'b0; loop_on = 1'b1;
        acc_state = 0; last_err = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_extremes();
        test_random_settings();
        test_full_rate();
        $display("covered %0d items over directed extremes, gain and decay extremes,",
                 items_sent);
        $display("random settings and a full-rate stretch; %0d results, %0d clipped",
                 results_seen, clipped_seen);
        if (mismatches == 0 && drive_expected.size() == 0) begin
            $display("pid_feedforward_decay_controller_test: clean");
        end else begin
            $display("pid_feedforward_decay_controller_test: errors");
        end
        $finish;
    end

endmodule
